// ===== sv/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int HDR_BYTES = 8;
  localparam int HDR_CNT_W = 3;
  localparam int HDR_W     = 8 * HDR_BYTES;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_CHANNEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_CHANNEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_FRAME_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_FRAME_LIMIT    = 2'd3;

  localparam logic [7:0]  RST_CONTROL_CHANNEL     = 8'd0;
  localparam logic [7:0]  RST_RESERVED_CHANNEL    = 8'd255;
  localparam logic [31:0] RST_CONTROL_FRAME_LIMIT = 32'd65536;
  localparam logic [31:0] RST_BULK_FRAME_LIMIT    = 32'd16777216;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_FATAL_LIMIT = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  control_channel;
    logic [7:0]  reserved_channel;
    logic [31:0] control_frame_limit;
    logic [31:0] bulk_frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic             with_hdr;
    logic [HDR_W-1:0] hdr;
    logic [7:0]       data;
    logic             last;
  } rec_t;

endpackage

// ===== sv/lpfd_in_if.sv =====
// Input byte stream channel.
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

// ===== sv/lpfd_out_if.sv =====
// Result channel: header reports, payload bytes and error reports.
interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  frame_channel;
  logic [31:0] payload_length;
  logic [7:0]  flag_bits;
  logic [15:0] reserved_bits;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  modport source (output valid, kind, status, frame_channel, payload_length, flag_bits,
                  reserved_bits, payload_byte, last_of_frame, input ready);
  modport sink (input valid, kind, status, frame_channel, payload_length, flag_bits,
                reserved_bits, payload_byte, last_of_frame, output ready);
endinterface

// ===== sv/lpfd_front.sv =====
// Front end: header collection, header checks and payload tracking.
module lpfd_front (
  input  logic               clk,
  input  logic               rst_n,
  lpfd_in_if.sink            in_ch,
  input  lpfd_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output lpfd_pkg::rec_t     push_rec
);

  lpfd_pkg::phase_t                   phase_r, phase_nxt;
  logic [lpfd_pkg::HDR_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [lpfd_pkg::HDR_W-1:0]         hdr_r, hdr_nxt;
  logic [31:0]                        rem_r, rem_nxt;

  logic                               fire;
  logic                               eob;
  logic                               hdr_done;
  logic [lpfd_pkg::HDR_W-1:0]         shifted;
  logic [7:0]                         chan;
  logic [31:0]                        len;
  logic [31:0]                        limit;
  logic [1:0]                         hdr_st;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign eob         = in_ch.end_of_buffer;
  assign shifted     = {hdr_r[lpfd_pkg::HDR_W-9:0], in_ch.data_byte};
  assign hdr_done    = (cnt_r == lpfd_pkg::HDR_CNT_W'(lpfd_pkg::HDR_BYTES - 1));
  assign chan        = shifted[31:24];
  assign len         = shifted[63:32];

  always_comb begin
    limit = (chan == cfg.control_channel) ? cfg.control_frame_limit : cfg.bulk_frame_limit;
    if (chan == cfg.reserved_channel) begin
      hdr_st = lpfd_pkg::ST_MALFORMED;
    end else if (len > limit) begin
      hdr_st = lpfd_pkg::ST_FATAL_LIMIT;
    end else begin
      hdr_st = lpfd_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        lpfd_pkg::PH_DROP: begin
          if (eob) phase_nxt = lpfd_pkg::PH_HEADER;
        end
        lpfd_pkg::PH_PAYLOAD: begin
          if (rem_r == 32'd1 || eob) phase_nxt = lpfd_pkg::PH_HEADER;
        end
        default: begin
          if (hdr_done) begin
            if (hdr_st != lpfd_pkg::ST_OK) begin
              phase_nxt = eob ? lpfd_pkg::PH_HEADER : lpfd_pkg::PH_DROP;
            end else if (len == 32'd0 || eob) begin
              phase_nxt = lpfd_pkg::PH_HEADER;
            end else begin
              phase_nxt = lpfd_pkg::PH_PAYLOAD;
            end
          end else begin
            phase_nxt = lpfd_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    push     = 1'b0;
    push_rec = '0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    hdr_nxt  = hdr_r;
    if (fire) begin
      case (phase_r)
        lpfd_pkg::PH_DROP: begin
          cnt_nxt = '0;
        end
        lpfd_pkg::PH_PAYLOAD: begin
          push              = 1'b1;
          rem_nxt           = rem_r - 32'd1;
          push_rec.with_hdr = 1'b1;
          push_rec.hdr      = hdr_r;
          push_rec.data     = in_ch.data_byte;
          push_rec.status   = lpfd_pkg::ST_OK;
          if (rem_r == 32'd1) begin
            push_rec.kind = lpfd_pkg::KIND_PAYLOAD;
            push_rec.last = 1'b1;
            cnt_nxt       = '0;
          end else if (eob) begin
            push_rec.kind   = lpfd_pkg::KIND_ERROR;
            push_rec.status = lpfd_pkg::ST_TRUNCATED;
            push_rec.last   = 1'b1;
            rem_nxt         = '0;
            cnt_nxt         = '0;
          end else begin
            push_rec.kind = lpfd_pkg::KIND_PAYLOAD;
            push_rec.last = 1'b0;
          end
        end
        default: begin
          hdr_nxt = shifted;
          if (!hdr_done) begin
            cnt_nxt = cnt_r + 1'b1;
            if (eob) begin
              cnt_nxt         = '0;
              push            = 1'b1;
              push_rec.kind   = lpfd_pkg::KIND_ERROR;
              push_rec.status = lpfd_pkg::ST_TRUNCATED;
              push_rec.last   = 1'b1;
            end
          end else begin
            cnt_nxt           = '0;
            push              = 1'b1;
            push_rec.with_hdr = 1'b1;
            push_rec.hdr      = shifted;
            push_rec.kind     = lpfd_pkg::KIND_HEADER;
            push_rec.status   = hdr_st;
            push_rec.last     = 1'b1;
            if (hdr_st == lpfd_pkg::ST_OK) begin
              if (len == 32'd0) begin
                rem_nxt = '0;
              end else if (eob) begin
                push_rec.kind   = lpfd_pkg::KIND_ERROR;
                push_rec.status = lpfd_pkg::ST_TRUNCATED;
                rem_nxt         = '0;
              end else begin
                push_rec.last = 1'b0;
                rem_nxt       = len;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpfd_pkg::PH_HEADER;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

// ===== sv/lpfd_queue.sv =====
// Small request queue between the front end and the output stage.
module lpfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpfd_pkg::rec_t push_rec,
  input  logic           pop,
  output lpfd_pkg::rec_t pop_rec,
  output logic           not_empty,
  output logic           full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpfd_pkg::rec_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign count     = cnt_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== sv/lpfd_back.sv =====
// Output stage: unpacks queued requests into the registered result channel.
module lpfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lpfd_pkg::rec_t q_rec,
  input  logic           q_not_empty,
  output logic           pop,
  lpfd_out_if.source     out_ch
);

  logic                        valid_r, valid_nxt;
  logic [1:0]                  kind_r;
  logic [1:0]                  status_r;
  logic [7:0]                  chan_r;
  logic [31:0]                 len_r;
  logic [7:0]                  flags_r;
  logic [15:0]                 rsvd_r;
  logic [7:0]                  byte_r;
  logic                        last_r;
  logic [lpfd_pkg::HDR_W-1:0]  hdr;

  assign pop       = q_not_empty && (!valid_r || out_ch.ready);
  assign valid_nxt = pop || (valid_r && !out_ch.ready);
  assign hdr       = q_rec.with_hdr ? q_rec.hdr : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= q_rec.kind;
      status_r <= q_rec.status;
      chan_r   <= hdr[31:24];
      len_r    <= hdr[63:32];
      flags_r  <= hdr[23:16];
      rsvd_r   <= hdr[15:0];
      byte_r   <= q_rec.data;
      last_r   <= q_rec.last;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.status         = status_r;
  assign out_ch.frame_channel  = chan_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.flag_bits      = flags_r;
  assign out_ch.reserved_bits  = rsvd_r;
  assign out_ch.payload_byte   = byte_r;
  assign out_ch.last_of_frame  = last_r;

endmodule

// ===== sv/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
//
// in_ch carries one stream byte per request with an end-of-buffer mark.
// Each frame starts with an 8-byte big-endian header (length, channel,
// flags, reserved). out_ch returns a header report per header, then one
// request per payload byte, the frame's final request marked last.
// Short headers and short payloads give a truncated error report; a
// malformed or over-limit header makes the block drop bytes up to the end
// of the buffer. cfg_we/cfg_index/cfg_data set channel numbers and limits;
// the user must write them only while the block is idle (unenforced).
// Throughput: one byte per clock, sustained, while out_ch is taken.
// Path: the edge that takes a byte writes its result into the queue, and
// the output register loads it when out_ch is free to take a new result.
// Reset (rst_n low, synchronous) restores register defaults, empties the
// queue and restarts header collection. When out_ch stalls, results pile up
// in a QUEUE_DEPTH-entry queue; in_ch.ready drops while it is full.
module length_prefixed_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lpfd_in_if.sink                            in_ch,
  lpfd_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [lpfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lpfd_pkg::cfg_t cfg_r;
  lpfd_pkg::rec_t push_rec;
  lpfd_pkg::rec_t q_rec;
  logic           push;
  logic           pop;
  logic           q_not_empty;
  logic           q_full;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_channel     <= lpfd_pkg::RST_CONTROL_CHANNEL;
      cfg_r.reserved_channel    <= lpfd_pkg::RST_RESERVED_CHANNEL;
      cfg_r.control_frame_limit <= lpfd_pkg::RST_CONTROL_FRAME_LIMIT;
      cfg_r.bulk_frame_limit    <= lpfd_pkg::RST_BULK_FRAME_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        lpfd_pkg::CFG_CONTROL_CHANNEL:     cfg_r.control_channel     <= cfg_data[7:0];
        lpfd_pkg::CFG_RESERVED_CHANNEL:    cfg_r.reserved_channel    <= cfg_data[7:0];
        lpfd_pkg::CFG_CONTROL_FRAME_LIMIT: cfg_r.control_frame_limit <= cfg_data[31:0];
        lpfd_pkg::CFG_BULK_FRAME_LIMIT:    cfg_r.bulk_frame_limit    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  lpfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  lpfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .pop_rec   (q_rec),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  lpfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rec       (q_rec),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (q_count != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
    else $error("input ready does not follow queue space");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == lpfd_pkg::KIND_ERROR |->
      out_ch.last_of_frame && out_ch.status == lpfd_pkg::ST_TRUNCATED)
    else $error("error report not marked last or not truncated");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == lpfd_pkg::KIND_PAYLOAD |->
      out_ch.status == lpfd_pkg::ST_OK)
    else $error("payload byte with non-ok status");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
